>>> sv/otb_pkg.sv
// Shared types and default sizes for the one-shot timer bank.
package otb_pkg;

  localparam int DEF_TIMER_SLOTS  = 16;
  localparam int DEF_FLAG_ID_BITS = 8;
  localparam int DEF_TIME_BITS    = 32;
  localparam int STAMP_BITS       = 16;

  typedef enum logic [1:0] {
    MODE_ARM    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_TICK   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_EXPIRE = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

endpackage

>>> sv/otb_slot_mem.sv
// Slot memory: flag, remaining time and stamp per slot, one write and one registered read port.
module otb_slot_mem import otb_pkg::*; #(
  parameter int DEPTH = DEF_TIMER_SLOTS,
  parameter int AW    = 4,
  parameter int DW    = DEF_FLAG_ID_BITS + DEF_TIME_BITS + STAMP_BITS
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/otb_free_find.sv
// Lowest free slot search over the armed bits.
module otb_free_find import otb_pkg::*; #(
  parameter int SLOTS = DEF_TIMER_SLOTS,
  parameter int AW    = 4
) (
  input  logic [SLOTS-1:0] armed,
  output logic             any_free,
  output logic [AW-1:0]    free_idx
);

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    // scan downward so the lowest free slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed[i]) begin
        any_free = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

endmodule

>>> sv/one_shot_timer_bank.sv
// Top level of the one-shot timer bank: control, armed bits and output register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------
//   request | in_valid  | in_stall  | mode, flag_id, amount
//   event   | out_valid | out_stall | event_kind, event_flag, last
//
// An arm is taken in S_IDLE; an arm that finds the bank full also passes through S_EMIT to report the reject.
// Cancel and tick walk the slot memory one slot per cycle behind its registered
// read, unless a stalled output holds the walk; a request that ends in an event
// then passes through S_EMIT, where its event waits out any output stall.
// Reset (rst, synchronous) clears the armed bits and the arm counter; no clearing pass.
// A stalled event output holds the tick walk only when a second expiry must push an event out.
module one_shot_timer_bank import otb_pkg::*; #(
  parameter int TIMER_SLOTS  = DEF_TIMER_SLOTS,
  parameter int FLAG_ID_BITS = DEF_FLAG_ID_BITS,
  parameter int TIME_BITS    = DEF_TIME_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              mode,
  input  logic [FLAG_ID_BITS-1:0] flag_id,
  input  logic [TIME_BITS-1:0]    amount,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              event_kind,
  output logic [FLAG_ID_BITS-1:0] event_flag,
  output logic                    last
);

  localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int ENTRY_W = FLAG_ID_BITS + TIME_BITS + STAMP_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

  state_t state, state_next;

  logic [TIMER_SLOTS-1:0]  armed, armed_next;
  logic [STAMP_BITS-1:0]   arm_counter;
  logic                    op_tick;
  logic [FLAG_ID_BITS-1:0] op_flag;
  logic [TIME_BITS-1:0]    op_amount;
  logic [SLOT_W-1:0]       eval_idx;
  logic                    best_valid;
  logic [SLOT_W-1:0]       best_idx;
  logic [STAMP_BITS-1:0]   best_age;
  logic                    pend_valid;
  logic [FLAG_ID_BITS-1:0] pend_flag;
  kind_t                   res_kind;
  logic [FLAG_ID_BITS-1:0] res_flag;
  kind_t                   out_kind;

  logic                    any_free;
  logic [SLOT_W-1:0]       free_idx;
  logic                    mem_wr_en, mem_rd_en;
  logic [SLOT_W-1:0]       mem_wr_addr, mem_rd_addr;
  logic [ENTRY_W-1:0]      mem_wr_data, rd_data;

  logic [FLAG_ID_BITS-1:0] e_flag;
  logic [TIME_BITS-1:0]    e_rem;
  logic [STAMP_BITS-1:0]   e_stamp;
  logic [STAMP_BITS-1:0]   e_age;

  logic in_acc, out_free, start_walk, arm_ok, arm_full;
  logic slot_on, expire, match, take, walk_go, walk_done;
  logic push_pend, emit_go, cancel_hit;
  logic [SLOT_W-1:0] cancel_idx;

  otb_free_find #(.SLOTS(TIMER_SLOTS), .AW(SLOT_W)) u_free (
    .armed    (armed),
    .any_free (any_free),
    .free_idx (free_idx)
  );

  otb_slot_mem #(.DEPTH(TIMER_SLOTS), .AW(SLOT_W), .DW(ENTRY_W)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  assign e_stamp = rd_data[STAMP_BITS-1:0];
  assign e_rem   = rd_data[STAMP_BITS +: TIME_BITS];
  assign e_flag  = rd_data[STAMP_BITS + TIME_BITS +: FLAG_ID_BITS];
  assign e_age   = arm_counter - e_stamp;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // control outputs
  always_comb begin
    start_walk = in_acc && (mode == MODE_CANCEL || mode == MODE_TICK);
    arm_ok     = in_acc && (mode == MODE_ARM) && any_free;
    arm_full   = in_acc && (mode == MODE_ARM) && !any_free;
    slot_on    = armed[eval_idx];
    expire     = op_tick && slot_on && (op_amount >= e_rem);
    match      = !op_tick && slot_on && (e_flag == op_flag);
    take       = match && (!best_valid || e_age < best_age);
    walk_go    = (state == S_WALK) && !(expire && pend_valid && !out_free);
    walk_done  = walk_go && (eval_idx == LAST_SLOT);
    push_pend  = walk_go && expire && pend_valid;
    emit_go    = (state == S_EMIT) && out_free;
    cancel_hit = walk_done && !op_tick && (best_valid || take);
    cancel_idx = take ? eval_idx : best_idx;

    mem_rd_en   = start_walk || (walk_go && !walk_done);
    mem_rd_addr = start_walk ? '0 : eval_idx + SLOT_W'(1);

    mem_wr_en   = arm_ok || (walk_go && op_tick && slot_on && !expire);
    mem_wr_addr = arm_ok ? free_idx : eval_idx;
    mem_wr_data = arm_ok ? {flag_id, amount, arm_counter}
                         : {e_flag, e_rem - op_amount, e_stamp};

    armed_next = armed;
    if (arm_ok) begin
      armed_next[free_idx] = 1'b1;
    end
    if (walk_go && expire) begin
      armed_next[eval_idx] = 1'b0;
    end
    if (cancel_hit) begin
      armed_next[cancel_idx] = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (arm_full) begin
          state_next = S_EMIT;
        end else if (start_walk) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          if (op_tick) begin
            state_next = (expire || pend_valid) ? S_EMIT : S_IDLE;
          end else begin
            state_next = cancel_hit ? S_EMIT : S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      armed       <= '0;
      arm_counter <= '0;
      pend_valid  <= 1'b0;
      best_valid  <= 1'b0;
    end else begin
      state <= state_next;
      armed <= armed_next;
      if (arm_ok) begin
        arm_counter <= arm_counter + STAMP_BITS'(1);
      end
      if (start_walk || walk_done) begin
        pend_valid <= 1'b0;
        best_valid <= 1'b0;
      end else if (walk_go) begin
        if (expire) begin
          pend_valid <= 1'b1;
        end
        if (take) begin
          best_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_walk) begin
      op_tick   <= (mode == MODE_TICK);
      op_flag   <= flag_id;
      op_amount <= amount;
      eval_idx  <= '0;
    end else if (walk_go && !walk_done) begin
      eval_idx <= eval_idx + SLOT_W'(1);
    end
    if (walk_go && take) begin
      best_idx <= eval_idx;
      best_age <= e_age;
    end
    if (walk_go && expire) begin
      pend_flag <= e_flag;
    end
    // stage the final event of the request
    if (arm_full) begin
      res_kind <= KIND_REJECT;
      res_flag <= flag_id;
    end else if (walk_done) begin
      res_kind <= op_tick ? KIND_EXPIRE : KIND_CANCEL;
      res_flag <= op_tick ? (expire ? e_flag : pend_flag) : op_flag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_pend || emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_pend) begin
      out_kind   <= KIND_EXPIRE;
      event_flag <= pend_flag;
      last       <= 1'b0;
    end else if (emit_go) begin
      out_kind   <= res_kind;
      event_flag <= res_flag;
      last       <= 1'b1;
    end
  end

  assign event_kind = out_kind;

  a_walk_no_arm: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |=> $countones(armed) <= $past($countones(armed)))
    else $error("armed count grew during a slot walk");

  a_arm_grows: assert property (@(posedge clk) disable iff (rst)
    arm_ok |=> $countones(armed) == $past($countones(armed)) + 1)
    else $error("successful arm did not take exactly one slot");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("expiry event left pending after walk");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_EXPIRE |-> last)
    else $error("cancel or reject event without last");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the one-shot timer bank: predicts every event and checks it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import otb_pkg::*;

  localparam int SLOTS     = DEF_TIMER_SLOTS;
  localparam int FLAG_W    = DEF_FLAG_ID_BITS;
  localparam int TIME_W    = DEF_TIME_BITS;
  localparam int HOLD_LEN  = 300;
  localparam int IDLE_MAX  = 3000;
  localparam int SETTLE    = 40;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct {
    kind_t             kind;
    logic [FLAG_W-1:0] flag;
    logic              last;
  } timer_event_t;

  class timer_bank_scoreboard;
    logic              armed[SLOTS];
    logic [FLAG_W-1:0] slot_flag[SLOTS];
    logic [TIME_W-1:0] slot_left[SLOTS];
    logic [15:0]       slot_stamp[SLOTS];
    logic [15:0]       arm_count;
    timer_event_t      event_q[$];
    int                errors;

    function new();
      foreach (armed[i]) armed[i] = 1'b0;
      arm_count = '0;
      errors = 0;
    endfunction

    function void push_event(kind_t kind, logic [FLAG_W-1:0] flag);
      timer_event_t e;
      e.kind = kind;
      e.flag = flag;
      e.last = 1'b0;
      event_q.push_back(e);
    endfunction

    // Work out the events caused by one accepted request.
    function void note_request(logic [1:0] mode, logic [FLAG_W-1:0] flag,
                               logic [TIME_W-1:0] amount);
      int n;
      int best;
      logic [15:0] age;
      logic [15:0] best_age;
      n = 0;
      best = -1;
      best_age = '0;
      case (mode)
        MODE_ARM: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!armed[i] && best < 0) begin
              best = i;
            end
          end
          if (best >= 0) begin
            armed[best] = 1'b1;
            slot_flag[best] = flag;
            slot_left[best] = amount;
            slot_stamp[best] = arm_count;
            arm_count = arm_count + 16'd1;
          end else begin
            push_event(KIND_REJECT, flag);
            n = 1;
          end
        end
        MODE_CANCEL: begin
          // newest timer of the flag: smallest age, lowest slot on a tie
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i] && slot_flag[i] == flag) begin
              age = arm_count - slot_stamp[i];
              if (best < 0 || age < best_age) begin
                best = i;
                best_age = age;
              end
            end
          end
          if (best >= 0) begin
            armed[best] = 1'b0;
            push_event(KIND_CANCEL, flag);
            n = 1;
          end
        end
        MODE_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (armed[i]) begin
              if (amount >= slot_left[i]) begin
                armed[i] = 1'b0;
                push_event(KIND_EXPIRE, slot_flag[i]);
                n++;
              end else begin
                slot_left[i] = slot_left[i] - amount;
              end
            end
          end
        end
        default: ;
      endcase
      if (n > 0) event_q[event_q.size()-1].last = 1'b1;
    endfunction

    function void check_event(logic [1:0] kind, logic [FLAG_W-1:0] flag, logic last);
      timer_event_t e;
      if (event_q.size() == 0) begin
        $error("unexpected event: event_kind=%0d event_flag=%0d last=%0b", kind, flag, last);
        errors++;
        return;
      end
      e = event_q.pop_front();
      if (kind !== e.kind) begin
        $error("event_kind: expected %0d, got %0d", e.kind, kind);
        errors++;
      end
      if (flag !== e.flag) begin
        $error("event_flag: expected %0d, got %0d", e.flag, flag);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return event_q.size();
    endfunction

    function void report_leftover();
      if (event_q.size() != 0) begin
        $error("%0d expected events never arrived", event_q.size());
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        mode = MODE_ARM;
  logic [FLAG_W-1:0] flag_id = '0;
  logic [TIME_W-1:0] amount = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        event_kind;
  logic [FLAG_W-1:0] event_flag;
  logic              last;

  timer_bank_scoreboard sb = new();
  bit                   hold_events = 1'b0;
  bit                   sender_quiet = 1'b0;
  int                   idle_cycles = 0;
  logic [FLAG_W-1:0]    flag_pool[4];

  one_shot_timer_bank dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .flag_id    (flag_id),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .event_flag (event_flag),
    .last       (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_event(event_kind, event_flag, last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_MAX);
    $display("*** FAILED ***");
    $finish;
  end

  // Event receiver: random stalls, quiet stretches, and one long hold on request.
  initial begin
    int  pick;
    int  len;
    bit  val;
    forever begin
      if (hold_events) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_events = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          len = $urandom_range(1, 8);
          val = 1'b0;
        end else if (pick < 60) begin
          len = $urandom_range(50, 150);
          val = 1'b0;
        end else if (pick < 92) begin
          len = $urandom_range(1, 3);
          val = 1'b1;
        end else begin
          len = $urandom_range(10, 40);
          val = 1'b1;
        end
        @(negedge clk);
        out_stall <= val;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (sender_quiet || pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request, hold it until accepted, then idle for a random gap.
  task automatic send_request(logic [1:0] m, logic [FLAG_W-1:0] f, logic [TIME_W-1:0] a);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    flag_id <= f;
    amount <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(m, f, a);
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering until every expected event is out and the walk has settled.
  task automatic drain_events();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(int count, int arm_pct, int cancel_pct, int tick_pct);
    int                pick;
    logic [FLAG_W-1:0] f;
    logic [TIME_W-1:0] a;
    foreach (flag_pool[i]) flag_pool[i] = FLAG_W'($urandom_range(0, 255));
    for (int k = 0; k < count; k++) begin
      f = ($urandom_range(0, 99) < 80) ? flag_pool[2'($urandom_range(0, 3))]
                                       : FLAG_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < arm_pct) begin
        pick = $urandom_range(0, 99);
        a = (pick < 70) ? TIME_W'($urandom_range(0, 2000)) :
            (pick < 90) ? TIME_W'($urandom_range(0, 60)) : TIME_W'($urandom());
        send_request(MODE_ARM, f, a);
      end else if (pick < arm_pct + cancel_pct) begin
        send_request(MODE_CANCEL, f, TIME_W'($urandom()));
      end else if (pick < arm_pct + cancel_pct + tick_pct) begin
        pick = $urandom_range(0, 99);
        a = (pick < 60) ? TIME_W'($urandom_range(0, 400)) :
            (pick < 90) ? TIME_W'($urandom_range(0, 3000)) : TIME_W'($urandom());
        send_request(MODE_TICK, f, a);
      end else begin
        send_request(MODE_NONE, f, TIME_W'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty bank: cancel and tick produce nothing
    send_request(MODE_CANCEL, 8'h00, 32'h0);
    send_request(MODE_TICK, 8'h00, 32'h0);
    // zero duration expires on the next tick even with zero elapsed time
    send_request(MODE_ARM, 8'h00, 32'h0);
    send_request(MODE_TICK, 8'h00, 32'h0);
    // cancel picks the newest of several timers of one flag
    send_request(MODE_ARM, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_ARM, 8'hFF, 32'd5);
    send_request(MODE_ARM, 8'hFF, 32'd7);
    send_request(MODE_CANCEL, 8'hFF, 32'h0);
    send_request(MODE_TICK, 8'hFF, 32'd6);
    send_request(MODE_NONE, 8'hA5, 32'h5A5A_5A5A);
    // fill the bank, overflow it, then expire every slot in one tick
    for (int i = 0; i < SLOTS - 1; i++) begin
      send_request(MODE_ARM, FLAG_W'($urandom_range(0, 255)), TIME_W'($urandom()));
    end
    send_request(MODE_ARM, 8'h3C, 32'd1);
    send_request(MODE_TICK, 8'h00, 32'hFFFF_FFFF);

    run_phase(40, 60, 20, 15);
    run_phase(40, 45, 25, 25);
    hold_events = 1'b1;
    run_phase(40, 45, 10, 42);
    drain_events();
    run_phase(40, 70, 10, 17);
    sender_quiet = 1'b1;
    run_phase(30, 40, 25, 30);
    sender_quiet = 1'b0;
    drain_events();
    run_phase(40, 30, 40, 27);
    run_phase(40, 55, 15, 27);
    drain_events();
    run_phase(40, 50, 20, 27);
    run_phase(30, 35, 20, 42);

    drain_events();
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
